FILE: rtl/integer_set_table_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer set table
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SET_TABLE_TOP_DEFINES_SVH
`define INTEGER_SET_TABLE_TOP_DEFINES_SVH

// plain property, checked every cycle out of reset
`define IST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define IST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Types and constants shared by the integer set table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

  localparam int ENTRIES     = 64;
  localparam int KEY_W       = 32;
  localparam int OPC_W       = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int CNT_W       = $clog2(ENTRIES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OPC_W-1:0] OPC_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OPC_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_REMOVE,
    KIND_QUERY
  } kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_UPD
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
  } item_t;

  typedef struct packed {
    logic                    was_present;
    logic [COUNT_OUT_W-1:0]  member_count;
    logic                    status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/integer_set_table_top.sv
// ----------------------------------------------------------------------------
// integer_set_table_top
// Bounded set of 32-bit keys with insert, remove and membership query.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode_i and key_i with start_i; the item is taken at a clock edge
//   where start_i is high and busy_o is low. Opcode 0 inserts, 1 removes,
//   2 queries; 3 behaves as a query.
//   Each item gives one result, shown for a single cycle with valid_o high:
//   was_present_o (key held before the item), member_count_o (keys held
//   after it) and status_o (1 when an insert found the table full).
//   The back end holds one item at a time: its BK_IDLE state pops the queue
//   head and registers the parallel key compare, its BK_UPD state updates the
//   store. A 2-entry queue lets the front take items while the back end is
//   busy; busy_o rises when that queue is full.
//   Results cannot be held off; they must be taken the cycle they appear.
//   Reset clears all valid bits, the count and the queue at once; the block
//   takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_table_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ist_pkg::OPC_W-1:0]         opcode_i,
  input  logic signed [ist_pkg::KEY_W-1:0]  key_i,
  output logic                              valid_o,
  output logic                              was_present_o,
  output logic [ist_pkg::COUNT_OUT_W-1:0]   member_count_o,
  output logic                              status_o
);

  logic              head_valid;
  ist_pkg::item_t    head;
  logic              pop;
  ist_pkg::result_t  result;

  ist_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .key_i        ($unsigned(key_i)),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  ist_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .result_o     (result)
  );

  assign was_present_o  = result.was_present;
  assign member_count_o = result.member_count;
  assign status_o       = result.status;

endmodule

`default_nettype wire

FILE: rtl/ist_front.sv
// ----------------------------------------------------------------------------
// ist_front
// Accepts items, classifies the opcode and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ist_pkg::OPC_W-1:0]    opcode_i,
  input  logic [ist_pkg::KEY_W-1:0]    key_i,
  output logic                         head_valid_o,
  output ist_pkg::item_t               head_o,
  input  logic                         pop_i
);

  ist_pkg::item_t                  queue_q [ist_pkg::QUEUE_DEPTH];
  logic [ist_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ist_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ist_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            push;
  logic                            pop;
  ist_pkg::item_t                  new_item;

  assign busy_o       = (cnt_q == ist_pkg::QCNT_W'(ist_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign push         = start_i && !busy_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    new_item.key = key_i;
    unique case (opcode_i)
      ist_pkg::OPC_INSERT: begin
        new_item.kind = ist_pkg::KIND_INSERT;
      end
      ist_pkg::OPC_REMOVE: begin
        new_item.kind = ist_pkg::KIND_REMOVE;
      end
      default: begin
        // query and the unused code both only look up
        new_item.kind = ist_pkg::KIND_QUERY;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ist_pkg::QPTR_W'(ist_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + ist_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ist_pkg::QPTR_W'(ist_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + ist_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + ist_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - ist_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ist_back.sv
// ----------------------------------------------------------------------------
// ist_back
// Key store with valid bits: parallel compare, then update and result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_set_table_top_defines.svh"

module ist_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  ist_pkg::item_t       head_i,
  output logic                 pop_o,
  output logic                 valid_o,
  output ist_pkg::result_t     result_o
);

  ist_pkg::back_state_e              state_q, state_d;
  logic [ist_pkg::KEY_W-1:0]         key_store_q [ist_pkg::ENTRIES];
  logic [ist_pkg::ENTRIES-1:0]       valid_q, valid_d;
  logic [ist_pkg::CNT_W-1:0]         count_q, count_d;
  logic [ist_pkg::ENTRIES-1:0]       eq_q, eq_d;
  ist_pkg::item_t                    cur_q;
  logic                              done_q, done_d;
  ist_pkg::result_t                  res_q, res_d;

  logic [ist_pkg::ENTRIES-1:0]       hit_v;
  logic [ist_pkg::ENTRIES-1:0]       free_v;
  logic [ist_pkg::ENTRIES-1:0]       pick_v;
  logic [ist_pkg::ENTRIES-1:0]       wr_v;
  logic                              present;
  logic                              full;

  assign valid_o  = done_q;
  assign result_o = res_q;

  // key equality against every slot, taken from the queue head
  always_comb begin
    for (int i = 0; i < ist_pkg::ENTRIES; i++) begin
      eq_d[i] = (key_store_q[i] == head_i.key);
    end
  end

  assign hit_v   = eq_q & valid_q;
  assign present = |hit_v;
  assign full    = &valid_q;
  assign free_v  = ~valid_q;
  assign pick_v  = free_v & (~free_v + ist_pkg::ENTRIES'(1));

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    valid_d = valid_q;
    count_d = count_q;
    wr_v    = '0;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      ist_pkg::BK_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = ist_pkg::BK_UPD;
        end
      end
      ist_pkg::BK_UPD: begin
        state_d           = ist_pkg::BK_IDLE;
        done_d            = 1'b1;
        res_d.was_present = present;
        res_d.status      = 1'b0;
        if (cur_q.kind == ist_pkg::KIND_INSERT && !present) begin
          if (full) begin
            res_d.status = 1'b1;
          end else begin
            wr_v    = pick_v;
            valid_d = valid_q | pick_v;
            count_d = count_q + ist_pkg::CNT_W'(1);
          end
        end else if (cur_q.kind == ist_pkg::KIND_REMOVE && present) begin
          valid_d = valid_q & ~hit_v;
          count_d = count_q - ist_pkg::CNT_W'(1);
        end
        res_d.member_count = ist_pkg::COUNT_OUT_W'(count_d);
      end
      default: begin
        state_d = ist_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ist_pkg::BK_IDLE;
      valid_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      cur_q <= head_i;
      eq_q  <= eq_d;
    end
    for (int i = 0; i < ist_pkg::ENTRIES; i++) begin
      if (wr_v[i]) begin
        key_store_q[i] <= cur_q.key;
      end
    end
  end

  `IST_ASSERT(a_count_tracks_valid, $countones(valid_q) == count_q, "count out of step with valid bits")
  `IST_ASSERT_IMP(a_single_hit, state_q == ist_pkg::BK_UPD, $onehot0(hit_v), "key held in two slots")
  `IST_ASSERT_IMP(a_done_after_upd, done_q, $past(state_q == ist_pkg::BK_UPD), "result without update")
  `IST_ASSERT_IMP(a_full_not_present, done_q && res_q.status, !res_q.was_present, "full flag on hit")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_set_table_top: a queued command driver with
// random idle gaps, a scoreboard that mirrors the key store and valid bits,
// and a monitor that checks every result item against the scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam logic [ist_pkg::OPC_W-1:0] OPC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 12;
  localparam int SEG_FILL = 0;
  localparam int SEG_DRAIN = 1;
  localparam int SEG_MIX = 2;

  typedef struct {
    logic [ist_pkg::OPC_W-1:0] opc;
    logic [ist_pkg::KEY_W-1:0] key;
    int unsigned               gap;
  } cmd_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start_i = 1'b0;
  logic [ist_pkg::OPC_W-1:0]           opcode_i = '0;
  logic signed [ist_pkg::KEY_W-1:0]    key_i = '0;
  logic                                busy_o;
  logic                                valid_o;
  logic                                was_present_o;
  logic [ist_pkg::COUNT_OUT_W-1:0]     member_count_o;
  logic                                status_o;

  cmd_t                                cmd_q[$];
  ist_pkg::result_t                    results_due[$];
  logic [ist_pkg::KEY_W-1:0]           key_pool[$];
  logic [ist_pkg::KEY_W-1:0]           key_tab[ist_pkg::ENTRIES];
  logic                                held[ist_pkg::ENTRIES];
  int unsigned                         idle_left = 0;
  int unsigned                         cycle_cnt = 0;
  int unsigned                         mismatch_cnt = 0;
  bit                                  timed_out = 1'b0;

  integer_set_table_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .key_i          (key_i),
    .valid_o        (valid_o),
    .was_present_o  (was_present_o),
    .member_count_o (member_count_o),
    .status_o       (status_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // set semantics: lookup, lowest free slot on insert, clear on remove
  function automatic ist_pkg::result_t apply_set_op(logic [ist_pkg::OPC_W-1:0] opc,
                                                    logic [ist_pkg::KEY_W-1:0] key);
    ist_pkg::result_t res;
    int               hit;
    int               free_slot;
    int unsigned      n_held;
    hit = -1;
    free_slot = -1;
    n_held = 0;
    for (int i = ist_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (held[i] && key_tab[i] == key) hit = i;
      if (!held[i]) free_slot = i;
    end
    res.was_present = (hit >= 0);
    res.status = 1'b0;
    if (opc == ist_pkg::OPC_INSERT && hit < 0) begin
      if (free_slot >= 0) begin
        key_tab[free_slot] = key;
        held[free_slot] = 1'b1;
      end else begin
        res.status = 1'b1;
      end
    end else if (opc == ist_pkg::OPC_REMOVE && hit >= 0) begin
      held[hit] = 1'b0;
    end
    for (int i = 0; i < ist_pkg::ENTRIES; i++) n_held += held[i];
    res.member_count = n_held[ist_pkg::COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic void add_cmd(logic [ist_pkg::OPC_W-1:0] opc,
                                  logic [ist_pkg::KEY_W-1:0] key, int unsigned gap);
    cmd_t c;
    c.opc = opc;
    c.key = key;
    c.gap = gap;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic int unsigned pick_gap(int style);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (style)
      0: return 0;
      1: return (r < 70) ? 0 : $urandom_range(1, 2);
      default: begin
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
      end
    endcase
  endfunction

  function automatic logic [ist_pkg::KEY_W-1:0] pool_key();
    if (key_pool.size() == 0) return $urandom;
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  function automatic void remember_key(logic [ist_pkg::KEY_W-1:0] key);
    key_pool.insert(key_pool.size(), key);
    if (key_pool.size() > 200) void'(key_pool.pop_front());
  endfunction

  // driver: start_i stays up while busy_o holds the item off
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      start_i <= 1'b0;
      opcode_i <= '0;
      key_i <= '0;
      idle_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        results_due.insert(results_due.size(), apply_set_op(opcode_i, key_i));
      end
      if (!start_i || !busy_o) begin
        if (idle_left > 0) begin
          start_i <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          start_i <= 1'b1;
          opcode_i <= c.opc;
          key_i <= c.key;
          idle_left <= c.gap;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ist_pkg::result_t want;
    if (rst_ni && valid_o) begin
      if (results_due.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) begin
          $display("unexpected result: was_present %0b count %0d status %0b",
                   was_present_o, member_count_o, status_o);
        end
      end else begin
        want = results_due.pop_front();
        if (want.was_present !== was_present_o || want.member_count !== member_count_o ||
            want.status !== status_o) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) begin
            $display("result mismatch: was_present %0b/%0b count %0d/%0d status %0b/%0b",
                     want.was_present, was_present_o, want.member_count, member_count_o,
                     want.status, status_o);
          end
        end
      end
    end
  end

  initial begin
    int                        n_rand;
    int                        seg;
    int                        seg_kind;
    int                        style;
    int                        len;
    int unsigned               r;
    logic [ist_pkg::OPC_W-1:0] opc;
    logic [ist_pkg::KEY_W-1:0] key;

    for (int i = 0; i < ist_pkg::ENTRIES; i++) begin
      held[i] = 1'b0;
      key_tab[i] = '0;
    end

    // directed: key extremes, duplicate insert, absent remove, spare opcode
    add_cmd(ist_pkg::OPC_INSERT, 32'h8000_0000, 0);
    add_cmd(ist_pkg::OPC_INSERT, 32'h7FFF_FFFF, 0);
    add_cmd(ist_pkg::OPC_INSERT, 32'h0000_0000, 1);
    add_cmd(ist_pkg::OPC_INSERT, 32'hFFFF_FFFF, 0);
    add_cmd(ist_pkg::OPC_INSERT, 32'h8000_0000, 0);
    add_cmd(ist_pkg::OPC_QUERY,  32'h7FFF_FFFF, 2);
    add_cmd(ist_pkg::OPC_QUERY,  32'h1234_5678, 0);
    add_cmd(OPC_SPARE,           32'h0000_0000, 0);
    add_cmd(OPC_SPARE,           32'h5555_5555, 3);
    add_cmd(ist_pkg::OPC_REMOVE, 32'h0BAD_BEEF, 0);
    add_cmd(ist_pkg::OPC_REMOVE, 32'h0000_0000, 0);
    add_cmd(ist_pkg::OPC_QUERY,  32'h0000_0000, 0);
    add_cmd(ist_pkg::OPC_REMOVE, 32'h0000_0000, 1);
    add_cmd(ist_pkg::OPC_INSERT, 32'hAAAA_AAAA, 0);
    add_cmd(ist_pkg::OPC_REMOVE, 32'hFFFF_FFFF, 0);
    add_cmd(ist_pkg::OPC_REMOVE, 32'h8000_0000, 0);
    add_cmd(ist_pkg::OPC_REMOVE, 32'h7FFF_FFFF, 5);
    add_cmd(ist_pkg::OPC_REMOVE, 32'hAAAA_AAAA, 0);
    add_cmd(ist_pkg::OPC_QUERY,  32'hAAAA_AAAA, 0);
    add_cmd(ist_pkg::OPC_REMOVE, 32'h5555_5555, 0);

    // random: fill past capacity, drain, and mixed traffic over a key pool
    n_rand = 0;
    seg = 0;
    while (n_rand < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      seg_kind = (seg == 0 || r < 2) ? SEG_FILL : (r < 4) ? SEG_DRAIN : SEG_MIX;
      style = $urandom_range(0, 3);
      len = (seg_kind == SEG_FILL) ? $urandom_range(66, 72) :
            (seg_kind == SEG_DRAIN) ? $urandom_range(20, 60) : $urandom_range(20, 80);
      for (int i = 0; i < len; i++) begin
        case (seg_kind)
          SEG_FILL: begin
            opc = ($urandom_range(0, 9) == 0) ? ist_pkg::OPC_QUERY : ist_pkg::OPC_INSERT;
            key = ($urandom_range(0, 7) == 0) ? pool_key() : $urandom;
          end
          SEG_DRAIN: begin
            opc = ($urandom_range(0, 9) == 0) ? OPC_SPARE : ist_pkg::OPC_REMOVE;
            key = ($urandom_range(0, 9) < 7) ? pool_key() : $urandom;
          end
          default: begin
            r = $urandom_range(0, 99);
            opc = (r < 35) ? ist_pkg::OPC_INSERT : (r < 65) ? ist_pkg::OPC_REMOVE :
                  (r < 90) ? ist_pkg::OPC_QUERY : OPC_SPARE;
            key = ($urandom_range(0, 9) < 7) ? pool_key() : $urandom;
          end
        endcase
        if (opc == ist_pkg::OPC_INSERT) remember_key(key);
        add_cmd(opc, key, pick_gap(style));
        n_rand++;
      end
      seg++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        while (cmd_q.size() != 0 || start_i || results_due.size() != 0) @(negedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any

    if (results_due.size() != 0) mismatch_cnt = mismatch_cnt + results_due.size();
    if (timed_out || mismatch_cnt != 0) begin
      $display("Mismatches found");
    end else begin
      $display("No mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
